>>> sv/assert_macros.svh
// Assertion macros used by the checker file of the scanner.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle: when ante holds, cons must hold too.
`define LMGS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication in the next cycle: when ante holds, cons must hold at the next edge.
`define LMGS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/lmgs_pkg.sv
// Types and constants shared by the LED matrix gray scanner modules.
package lmgs_pkg;

   // Field widths of the item channels.
   localparam int CMD_W      = 2;
   localparam int PIX_ROW_W  = 5;
   localparam int PIX_COL_W  = 5;
   localparam int PIX_VAL_W  = 4;
   localparam int REQ_DATA_W = 16;
   localparam int OUT_W      = 20;
   localparam int RSP_DATA_W = 48;

   // Bit positions inside rsp_tdata.
   localparam int ROW_LSB  = 0;
   localparam int COL_LSB  = 20;
   localparam int BUSY_BIT = 40;

   // Configuration port.
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 16;
   localparam int SLOT_TICKS_W = 16;

   localparam logic [CSR_IDX_W-1:0] REG_GRAY_MODE  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SLOT_TICKS = 1'd1;

   localparam logic                    RESET_GRAY_MODE  = 1'b1;
   localparam logic [SLOT_TICKS_W-1:0] RESET_SLOT_TICKS = 16'd100;

   // Gray slot counter and the two level counts.
   localparam int SLOT_W = 5;
   localparam logic [SLOT_W-1:0] LEVELS_TWO     = 5'd2;
   localparam logic [SLOT_W-1:0] LEVELS_SIXTEEN = 5'd16;

   typedef enum logic [CMD_W-1:0] {
      CMD_WRITE = 2'd0,
      CMD_START = 2'd1,
      CMD_TICK  = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_LOAD,
      ST_TAIL,
      ST_RESP
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic clr_step;
      logic do_write;
      logic do_start;
      logic do_tick;
      logic ld_step;
      logic push;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      cmd_type kind;
      logic    scanning;
      logic    slot_end;
      logic    row_end;
      logic    last_row;
      logic    ld_last;
      logic    clr_last;
      logic    out_free;
   } dp_stat_type;

endpackage

>>> sv/lmgs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module lmgs_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 400
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/lmgs_ctrl.sv
// Controller state machine of the scanner: sequences clear, item execution, row load and response.
module lmgs_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  lmgs_pkg::dp_stat_type stat,
   output lmgs_pkg::dp_cmd_type  cmd
);

   lmgs_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lmgs_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         lmgs_pkg::ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_last) begin
               state_in = lmgs_pkg::ST_IDLE;
            end
         end
         lmgs_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = lmgs_pkg::ST_EXEC;
            end
         end
         lmgs_pkg::ST_EXEC: begin
            state_in = lmgs_pkg::ST_RESP;
            unique case (stat.kind)
               lmgs_pkg::CMD_WRITE: begin
                  cmd.do_write = 1'b1;
               end
               lmgs_pkg::CMD_START: begin
                  if (!stat.scanning) begin
                     cmd.do_start = 1'b1;
                     state_in     = lmgs_pkg::ST_LOAD;
                  end
               end
               lmgs_pkg::CMD_TICK: begin
                  if (stat.scanning) begin
                     cmd.do_tick = 1'b1;
                     if (stat.slot_end && stat.row_end && !stat.last_row) begin
                        state_in = lmgs_pkg::ST_LOAD;
                     end
                  end
               end
               default: begin
                  state_in = lmgs_pkg::ST_RESP;
               end
            endcase
         end
         lmgs_pkg::ST_LOAD: begin
            cmd.ld_step = 1'b1;
            if (stat.ld_last) begin
               state_in = lmgs_pkg::ST_TAIL;
            end
         end
         lmgs_pkg::ST_TAIL: begin
            state_in = lmgs_pkg::ST_RESP;
         end
         lmgs_pkg::ST_RESP: begin
            if (stat.out_free) begin
               cmd.push = 1'b1;
               state_in = lmgs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lmgs_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

>>> sv/lmgs_dp.sv
// Datapath of the scanner: frame store, latched row levels, scan counters and result register.
module lmgs_dp #(
   parameter int PANEL_ROWS = 20,
   parameter int PANEL_COLS = 20,
   parameter int COL_GROUP  = 2
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  lmgs_pkg::dp_cmd_type                    cmd,
   output lmgs_pkg::dp_stat_type                   stat,
   input  logic [lmgs_pkg::REQ_DATA_W-1:0]         req_tdata,
   input  logic [lmgs_pkg::CMD_W-1:0]              req_tuser,
   input  logic                                    csr_valid,
   input  logic [lmgs_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [lmgs_pkg::CSR_DATA_W-1:0]         csr_data,
   input  logic                                    rsp_tready,
   output logic                                    rsp_tvalid,
   output logic [lmgs_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   output logic                                    rsp_tlast
);

   localparam int DEPTH    = PANEL_ROWS * PANEL_COLS;
   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int ROW_W    = $clog2(PANEL_ROWS);
   localparam int COL_W    = $clog2(PANEL_COLS);
   localparam int GRP_W    = $clog2(COL_GROUP);
   localparam int PJ_W     = $clog2(PANEL_COLS + COL_GROUP);
   localparam int HALF     = COL_GROUP / 2;
   localparam int ROW_HALF = PANEL_ROWS / 2;
   localparam int WIDE_W   = (PANEL_COLS > lmgs_pkg::OUT_W) ? PANEL_COLS : lmgs_pkg::OUT_W;
   localparam int VW       = lmgs_pkg::PIX_VAL_W;
   localparam int SW       = lmgs_pkg::SLOT_W;
   localparam int TW       = lmgs_pkg::SLOT_TICKS_W;

   // Latched item.
   lmgs_pkg::cmd_type             kind_ff;
   logic [lmgs_pkg::PIX_ROW_W-1:0] prow_ff;
   logic [lmgs_pkg::PIX_COL_W-1:0] pcol_ff;
   logic [VW-1:0]                  pval_ff;

   // Configuration registers.
   logic          gray_mode_ff;
   logic [TW-1:0] slot_ticks_ff;

   // Scan state.
   logic                  scanning_ff;
   logic [ROW_W-1:0]      scan_row_ff;
   logic [SW-1:0]         slot_ff;
   logic [TW-1:0]         tick_ff;
   logic [PANEL_COLS-1:0] col_on_ff;
   logic [VW-1:0]         levels_ff [PANEL_COLS];
   logic                  done_ff;

   // Row load pipeline.
   logic [COL_W-1:0]  ld_col_ff;
   logic [GRP_W-1:0]  ld_grp_ff;
   logic              cap_valid_ff;
   logic [COL_W-1:0]  cap_col_ff;
   logic              cap_dark_ff;
   logic [ADDR_W-1:0] clr_addr_ff;

   // Result register.
   logic                            rsp_valid_ff;
   logic [lmgs_pkg::RSP_DATA_W-1:0] rsp_data_ff;
   logic                            rsp_last_ff;

   logic [SW-1:0]         level_count;
   logic [VW-1:0]         level_top;
   logic [TW-1:0]         slot_len;
   logic [TW:0]           tick_inc;
   logic                  slot_end;
   logic                  row_end;
   logic                  last_row;
   logic [PANEL_COLS-1:0] clr_mask;

   logic              lower;
   logic              top_half;
   logic [ROW_W-1:0]  row_mirror;
   logic [ROW_W:0]    pi;
   logic [PJ_W-1:0]   j_ext;
   logic [PJ_W-1:0]   pj;
   logic              dark;
   logic [ADDR_W-1:0] rd_addr;

   logic              pix_in_range;
   logic [ADDR_W-1:0] pix_addr;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [VW-1:0]     wr_data;
   logic [VW-1:0]     rd_data;
   logic [VW-1:0]     cap_value;
   logic [VW-1:0]     clipped;

   logic [lmgs_pkg::OUT_W-1:0] row_vec;
   logic [WIDE_W-1:0]          col_wide;
   logic [lmgs_pkg::OUT_W-1:0] col_vec;

   // Slot timing and level count.
   always_comb begin
      level_count = gray_mode_ff ? lmgs_pkg::LEVELS_SIXTEEN : lmgs_pkg::LEVELS_TWO;
      level_top   = VW'(level_count - 1'b1);
      slot_len    = (slot_ticks_ff == '0) ? TW'(1) : slot_ticks_ff;
      tick_inc    = {1'b0, tick_ff} + (TW+1)'(1);
      slot_end    = tick_inc >= {1'b0, slot_len};
      row_end     = ({1'b0, slot_ff} + (SW+1)'(1)) >= {1'b0, level_count};
      last_row    = (32'(scan_row_ff) + 1) >= PANEL_ROWS;
      for (int j = 0; j < PANEL_COLS; j++) begin
         clr_mask[j] = (SW'(levels_ff[j]) == slot_ff);
      end
   end

   // Schematic-to-position remap of the column being fetched.
   always_comb begin
      lower      = 32'(ld_grp_ff) < HALF;
      top_half   = 32'(scan_row_ff) < ROW_HALF;
      row_mirror = ROW_W'(PANEL_ROWS - 1) - scan_row_ff;
      pi         = {(top_half ? scan_row_ff : row_mirror), ~lower};
      j_ext      = PJ_W'(ld_col_ff);
      if (lower) begin
         pj = top_half ? j_ext : j_ext + PJ_W'(HALF);
      end else begin
         pj = top_half ? j_ext - PJ_W'(HALF) : j_ext;
      end
      dark    = (32'(pi) >= PANEL_ROWS) || (32'(pj) >= PANEL_COLS);
      rd_addr = ADDR_W'(32'(pi) * PANEL_COLS + 32'(pj));
   end

   // Frame store write side: clearing sweep or pixel write.
   always_comb begin
      pix_in_range = (32'(prow_ff) < PANEL_ROWS) && (32'(pcol_ff) < PANEL_COLS);
      pix_addr     = ADDR_W'(32'(prow_ff) * PANEL_COLS + 32'(pcol_ff));
      wr_en        = cmd.clr_step || (cmd.do_write && pix_in_range);
      wr_addr      = cmd.clr_step ? clr_addr_ff : pix_addr;
      wr_data      = cmd.clr_step ? '0 : pval_ff;
      cap_value    = cap_dark_ff ? '0 : rd_data;
      clipped      = (cap_value < level_top) ? cap_value : level_top;
   end

   lmgs_ram #(
      .WIDTH (VW),
      .DEPTH (DEPTH)
   ) u_frame (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Item and capture payload.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         kind_ff <= lmgs_pkg::cmd_type'(req_tuser);
         prow_ff <= req_tdata[lmgs_pkg::PIX_ROW_W-1:0];
         pcol_ff <= req_tdata[lmgs_pkg::PIX_ROW_W +: lmgs_pkg::PIX_COL_W];
         pval_ff <= req_tdata[lmgs_pkg::PIX_ROW_W + lmgs_pkg::PIX_COL_W +: VW];
      end
      cap_col_ff  <= ld_col_ff;
      cap_dark_ff <= dark;
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         gray_mode_ff  <= lmgs_pkg::RESET_GRAY_MODE;
         slot_ticks_ff <= lmgs_pkg::RESET_SLOT_TICKS;
      end else if (csr_valid) begin
         unique case (csr_index)
            lmgs_pkg::REG_GRAY_MODE: begin
               gray_mode_ff <= csr_data[0];
            end
            lmgs_pkg::REG_SLOT_TICKS: begin
               slot_ticks_ff <= csr_data[TW-1:0];
            end
         endcase
      end
   end

   // Latched clipped levels of the current row.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < PANEL_COLS; j++) begin
            levels_ff[j] <= '0;
         end
      end else if (cap_valid_ff) begin
         levels_ff[cap_col_ff] <= clipped;
      end
   end

   // Scan state and load counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         scanning_ff  <= 1'b0;
         scan_row_ff  <= '0;
         slot_ff      <= '0;
         tick_ff      <= '0;
         col_on_ff    <= '0;
         done_ff      <= 1'b0;
         ld_col_ff    <= '0;
         ld_grp_ff    <= '0;
         cap_valid_ff <= 1'b0;
         clr_addr_ff  <= '0;
      end else begin
         cap_valid_ff <= cmd.ld_step;
         if (cmd.clr_step) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
         end
         if (cmd.accept) begin
            done_ff <= 1'b0;
         end
         if (cmd.do_start) begin
            scanning_ff <= 1'b1;
            scan_row_ff <= '0;
            slot_ff     <= '0;
            tick_ff     <= '0;
            col_on_ff   <= '0;
            ld_col_ff   <= '0;
            ld_grp_ff   <= '0;
         end
         if (cmd.do_tick) begin
            if (slot_end) begin
               tick_ff <= '0;
               if (row_end) begin
                  col_on_ff <= '0;
                  slot_ff   <= '0;
                  ld_col_ff <= '0;
                  ld_grp_ff <= '0;
                  if (last_row) begin
                     scanning_ff <= 1'b0;
                     scan_row_ff <= '0;
                     done_ff     <= 1'b1;
                  end else begin
                     scan_row_ff <= scan_row_ff + 1'b1;
                  end
               end else begin
                  col_on_ff <= col_on_ff & ~clr_mask;
                  slot_ff   <= slot_ff + 1'b1;
               end
            end else begin
               tick_ff <= tick_inc[TW-1:0];
            end
         end
         if (cmd.ld_step) begin
            ld_col_ff <= ld_col_ff + 1'b1;
            ld_grp_ff <= (32'(ld_grp_ff) == COL_GROUP - 1) ? '0 : ld_grp_ff + 1'b1;
         end
         if (cap_valid_ff) begin
            col_on_ff[cap_col_ff] <= (cap_value != '0);
         end
      end
   end

   // Drive pattern shown in a result.
   always_comb begin
      for (int b = 0; b < lmgs_pkg::OUT_W; b++) begin
         row_vec[b] = !(scanning_ff && (32'(scan_row_ff) == b));
      end
      col_wide = WIDE_W'(col_on_ff);
      col_vec  = scanning_ff ? col_wide[lmgs_pkg::OUT_W-1:0] : '0;
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.push) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         rsp_data_ff <= lmgs_pkg::RSP_DATA_W'({scanning_ff, col_vec, row_vec});
         rsp_last_ff <= done_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      stat.kind     = kind_ff;
      stat.scanning = scanning_ff;
      stat.slot_end = slot_end;
      stat.row_end  = row_end;
      stat.last_row = last_row;
      stat.ld_last  = (ld_col_ff == COL_W'(PANEL_COLS - 1));
      stat.clr_last = (clr_addr_ff == ADDR_W'(DEPTH - 1));
      stat.out_free = !rsp_valid_ff || rsp_tready;
   end

endmodule

>>> sv/led_matrix_gray_pwm_scanner.sv
// Flow: an accepted item passes the execute and response states and is handed to the result
// register; a start or a row-ending tick that loads a new row also passes the load state, one
// frame-store read per column, and a tail state. A new item is taken only once the last result
// is handed off; the single read port of the frame store sets the row load time.
// Reset: synchronous, active high; afterwards a clearing pass over all PANEL_ROWS * PANEL_COLS
// addresses zeroes the frame store, and no item is accepted until it ends.
module led_matrix_gray_pwm_scanner #(
   parameter int PANEL_ROWS = 20,
   parameter int PANEL_COLS = 20,
   parameter int COL_GROUP  = 2
) (
   input  logic                            clock,
   input  logic                            reset,
   // Input items.
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // tdata: pix_row[4:0], pix_col[9:5], pix_value[13:10], zero pad[15:14].
   input  logic [lmgs_pkg::REQ_DATA_W-1:0] req_tdata,
   // tuser: cmd[1:0] (write pixel, start frame scan, one tick).
   input  logic [lmgs_pkg::CMD_W-1:0]      req_tuser,
   // Result items.
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // tdata: row_drive[19:0], col_drive[39:20], busy_res[40], zero pad[47:41].
   output logic [lmgs_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // tlast: frame_done.
   output logic                            rsp_tlast,
   // Configuration writes.
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [lmgs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lmgs_pkg::CSR_DATA_W-1:0] csr_data
);

   // The controller steps each item through execute, an optional row load, and
   // the hand-off into the result register. The datapath holds the frame store,
   // the latched levels of the driven row and all scan counters.
   lmgs_pkg::dp_cmd_type  dp_cmd;
   lmgs_pkg::dp_stat_type dp_stat;

   // Configuration registers live in plain flops and take a write in any cycle.
   assign csr_ready = 1'b1;

   lmgs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (dp_stat),
      .cmd        (dp_cmd)
   );

   lmgs_dp #(
      .PANEL_ROWS (PANEL_ROWS),
      .PANEL_COLS (PANEL_COLS),
      .COL_GROUP  (COL_GROUP)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (dp_cmd),
      .stat       (dp_stat),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> sv/lmgs_chk.sv
// Port-level checker of the scanner's result channel, bound to the top level.
`include "assert_macros.svh"

module lmgs_chk (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [lmgs_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tlast
);

   logic [lmgs_pkg::OUT_W-1:0] rows;
   logic [lmgs_pkg::OUT_W-1:0] cols;
   logic                       busy;

   assign rows = rsp_tdata[lmgs_pkg::ROW_LSB +: lmgs_pkg::OUT_W];
   assign cols = rsp_tdata[lmgs_pkg::COL_LSB +: lmgs_pkg::OUT_W];
   assign busy = rsp_tdata[lmgs_pkg::BUSY_BIT];

   // A stalled result keeps its contents.
   `LMGS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "result changed while stalled")

   // The item that finishes a frame shows the panel released.
   `LMGS_ASSERT_NOW(a_done_idle, clock, reset, rsp_tvalid && rsp_tlast, !busy && (rows == '1), "frame end with drive still active")

   // Without a scan no column and no row is driven.
   `LMGS_ASSERT_NOW(a_idle_dark, clock, reset, rsp_tvalid && !busy, (cols == '0) && (rows == '1), "drive active while idle")

   // During a scan at most one row is pulled low.
   `LMGS_ASSERT_NOW(a_one_row, clock, reset, rsp_tvalid && busy, $onehot0(~rows), "more than one row driven")

endmodule

bind led_matrix_gray_pwm_scanner lmgs_chk u_lmgs_chk (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
